>>> src/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants of the UTF-8 decoder with surrogate pairing.
// ----------------------------------------------------------------------------
package utf8d_pkg;

	localparam int CP_W    = 21;
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [CP_W-1:0] CP_REPL   = 21'h00FFFD;
	localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;
	localparam logic [CP_W-1:0] CP_SUPP   = 21'h010000;
	localparam logic [CP_W-1:0] MIN_LEN1  = 21'h000080;
	localparam logic [CP_W-1:0] MIN_LEN2  = 21'h000800;
	localparam logic [CP_W-1:0] MIN_LEN3  = 21'h010000;
	localparam logic [5:0]      SUR_HIGH  = 6'b110110;
	localparam logic [5:0]      SUR_LOW   = 6'b110111;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            replaced;
		logic            stream_end;
		logic            last;
	} out_item_t;

	// One queue entry: the results of one input beat (one or two).
	typedef struct packed {
		logic      two;
		out_item_t r0;
		out_item_t r1;
	} entry_t;

	typedef enum logic [1:0] {
		LEAD_CHAR,
		LEAD_ERR,
		LEAD_OPEN
	} lead_kind_t;

endpackage

>>> src/utf8d_front.sv
// ----------------------------------------------------------------------------
// utf8d_front
// Decodes one byte per beat, pairs surrogates and builds a queue entry.
// ----------------------------------------------------------------------------
module utf8d_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_ok,
	input  utf8d_pkg::in_item_t in_item,
	output logic                wr,
	output utf8d_pkg::entry_t   wr_entry
);
	import utf8d_pkg::*;

	typedef struct packed {
		lead_kind_t      kind;
		logic [1:0]      n;
		logic [CP_W-1:0] bits;
	} lead_t;

	typedef struct packed {
		logic            hp;
		logic [9:0]      hb;
		logic [1:0]      n;
		logic [CP_W-1:0] cp0;
		logic            rep0;
		logic [CP_W-1:0] cp1;
		logic            rep1;
	} dlv_t;

	function automatic lead_t lead(input logic [7:0] b);
		lead_t l;
		l.kind = LEAD_ERR;
		l.n    = 2'd0;
		l.bits = '0;
		if (b < 8'h80) begin
			l.kind = LEAD_CHAR;
			l.bits = {13'd0, b};
		end else if (b < 8'hC2) begin
			l.kind = LEAD_ERR;
		end else if (b < 8'hE0) begin
			l.kind = LEAD_OPEN;
			l.n    = 2'd1;
			l.bits = {16'd0, b[4:0]};
		end else if (b < 8'hF0) begin
			l.kind = LEAD_OPEN;
			l.n    = 2'd2;
			l.bits = {17'd0, b[3:0]};
		end else if (b < 8'hF5) begin
			l.kind = LEAD_OPEN;
			l.n    = 2'd3;
			l.bits = {18'd0, b[2:0]};
		end
		return l;
	endfunction

	function automatic dlv_t add(input dlv_t d, input logic [CP_W-1:0] cp, input logic rep);
		dlv_t r;
		r = d;
		if (d.n == 2'd0) begin
			r.cp0  = cp;
			r.rep0 = rep;
		end else begin
			r.cp1  = cp;
			r.rep1 = rep;
		end
		r.n = d.n + 2'd1;
		return r;
	endfunction

	// surrogate test looks at bits 15:10 only
	function automatic dlv_t deliver(input logic hp, input logic [9:0] hb, input logic v,
			input logic err, input logic [CP_W-1:0] cp);
		dlv_t d;
		logic fin;
		logic is_high;
		logic is_low;
		d.hp   = hp;
		d.hb   = hb;
		d.n    = 2'd0;
		d.cp0  = CP_REPL;
		d.rep0 = 1'b1;
		d.cp1  = CP_REPL;
		d.rep1 = 1'b1;
		fin     = !v;
		is_high = cp[15:10] == SUR_HIGH;
		is_low  = cp[15:10] == SUR_LOW;
		if (!fin && hp) begin
			d.hp = 1'b0;
			if (err) begin
				d   = add(d, CP_REPL, 1'b1);
				fin = 1'b1;
			end else if (is_low) begin
				d   = add(d, CP_SUPP + {1'b0, hb, cp[9:0]}, 1'b0);
				fin = 1'b1;
			end else begin
				d = add(d, CP_REPL, 1'b1);
			end
		end
		if (!fin) begin
			if (err || is_low) begin
				d = add(d, CP_REPL, 1'b1);
			end else if (is_high) begin
				d.hp = 1'b1;
				d.hb = cp[9:0];
			end else begin
				d = add(d, cp, 1'b0);
			end
		end
		return d;
	endfunction

	logic [CP_W-1:0] pv_q, pv_n, pv_cat;
	logic [1:0]      bl_q, bl_n, sl_q, sl_n;
	logic            hp_q;
	logic [9:0]      hb_q;
	logic            u0_v, u0_err, u1_v, u1_err;
	logic [CP_W-1:0] u0_cp, u1_cp, least;
	lead_t           ld;
	dlv_t            d0, d1;
	out_item_t       r0, r1;
	logic [1:0]      nres;
	logic            eos;

	always_comb begin
		eos    = in_item.end_of_stream;
		ld     = lead(in_item.data_byte);
		pv_n   = pv_q;
		bl_n   = bl_q;
		sl_n   = sl_q;
		u0_v   = 1'b0;
		u0_err = 1'b0;
		u0_cp  = '0;
		u1_v   = 1'b0;
		u1_err = 1'b0;
		u1_cp  = '0;
		pv_cat = {pv_q[CP_W-7:0], in_item.data_byte[5:0]};
		case (sl_q)
			2'd1:    least = MIN_LEN1;
			2'd2:    least = MIN_LEN2;
			default: least = MIN_LEN3;
		endcase
		if (bl_q != 2'd0) begin
			if (in_item.data_byte[7:6] == 2'b10) begin
				pv_n = pv_cat;
				bl_n = bl_q - 2'd1;
				if (bl_q == 2'd1) begin
					u0_v   = 1'b1;
					u0_err = pv_cat < least || pv_cat > CP_MAX;
					u0_cp  = pv_cat;
					pv_n   = '0;
					sl_n   = 2'd0;
				end
			end else begin
				pv_n   = '0;
				bl_n   = 2'd0;
				sl_n   = 2'd0;
				u0_v   = 1'b1;
				u0_err = 1'b1;
				case (ld.kind)
					LEAD_CHAR: begin
						u1_v  = 1'b1;
						u1_cp = ld.bits;
					end
					LEAD_OPEN: begin
						pv_n = ld.bits;
						bl_n = ld.n;
						sl_n = ld.n;
					end
					default: begin
						u1_v   = 1'b1;
						u1_err = 1'b1;
					end
				endcase
			end
		end else begin
			case (ld.kind)
				LEAD_CHAR: begin
					u0_v  = 1'b1;
					u0_cp = ld.bits;
				end
				LEAD_OPEN: begin
					pv_n = ld.bits;
					bl_n = ld.n;
					sl_n = ld.n;
				end
				default: begin
					u0_v   = 1'b1;
					u0_err = 1'b1;
				end
			endcase
		end

		d0 = deliver(hp_q, hb_q, u0_v, u0_err, u0_cp);
		d1 = deliver(d0.hp, d0.hb, u1_v, u1_err, u1_cp);

		r0 = '{code_point: CP_REPL, replaced: 1'b1, stream_end: 1'b0, last: 1'b0};
		r1 = '{code_point: CP_REPL, replaced: 1'b1, stream_end: 1'b0, last: 1'b1};
		if (eos) begin
			if (bl_q != 2'd0 || hp_q) begin
				nres = 2'd2;
			end else begin
				nres = 2'd1;
			end
			if (nres == 2'd1) begin
				r0 = '{code_point: '0, replaced: 1'b0, stream_end: 1'b1, last: 1'b1};
			end else begin
				r1 = '{code_point: '0, replaced: 1'b0, stream_end: 1'b1, last: 1'b1};
			end
		end else begin
			nres = d0.n + d1.n;
			if (d0.n == 2'd0) begin
				r0.code_point = d1.cp0;
				r0.replaced   = d1.rep0;
				r1.code_point = d1.cp1;
				r1.replaced   = d1.rep1;
			end else if (d0.n == 2'd1) begin
				r0.code_point = d0.cp0;
				r0.replaced   = d0.rep0;
				r1.code_point = d1.cp0;
				r1.replaced   = d1.rep0;
			end else begin
				r0.code_point = d0.cp0;
				r0.replaced   = d0.rep0;
				r1.code_point = d0.cp1;
				r1.replaced   = d0.rep1;
			end
			r0.last = nres == 2'd1;
		end
		wr           = in_ok && nres != 2'd0;
		wr_entry.two = nres == 2'd2;
		wr_entry.r0  = r0;
		wr_entry.r1  = r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= '0;
			bl_q <= 2'd0;
			sl_q <= 2'd0;
			hp_q <= 1'b0;
			hb_q <= '0;
		end else if (in_ok) begin
			if (eos) begin
				pv_q <= '0;
				bl_q <= 2'd0;
				sl_q <= 2'd0;
				hp_q <= 1'b0;
				hb_q <= '0;
			end else begin
				pv_q <= pv_n;
				bl_q <= bl_n;
				sl_q <= sl_n;
				hp_q <= d1.hp;
				hb_q <= d1.hb;
			end
		end
	end

endmodule

>>> src/utf8d_queue.sv
// ----------------------------------------------------------------------------
// utf8d_queue
// Short entry queue between decoder and result serializer.
// ----------------------------------------------------------------------------
module utf8d_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  utf8d_pkg::entry_t wr_entry,
	input  logic              rd,
	output utf8d_pkg::entry_t head,
	output logic              full,
	output logic              empty
);
	import utf8d_pkg::*;

	entry_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_wr, do_rd;

	assign full  = cnt_q == QCNT_W'(QDEPTH);
	assign empty = cnt_q == '0;
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> src/utf8d_back.sv
// ----------------------------------------------------------------------------
// utf8d_back
// Serializes each queued entry into one or two result beats.
// ----------------------------------------------------------------------------
module utf8d_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  utf8d_pkg::entry_t    head,
	input  logic                 q_empty,
	input  logic                 pop,
	output logic                 q_rd,
	output utf8d_pkg::out_item_t out_item
);
	import utf8d_pkg::*;

	logic sub_q;
	logic take;

	assign take     = pop && !q_empty;
	assign out_item = sub_q ? head.r1 : head.r0;
	assign q_rd     = take && (sub_q || !head.two);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= 1'b0;
		end else if (take) begin
			sub_q <= !sub_q && head.two;
		end
	end

endmodule

>>> src/utf8_decoder_surrogate_filter_unit.sv
// ----------------------------------------------------------------------------
// utf8_decoder_surrogate_filter_unit
// UTF-8 byte stream to code point decoder with UTF-16 surrogate pairing.
// ----------------------------------------------------------------------------
// A byte's results are written to the queue as it is accepted. Throughput:
// one byte per cycle unless full; results leave one per cycle on pop, so a
// byte giving two results takes two pops. A four-entry queue decouples the sides.
// Reset: arst_n clears decoder state and the queue; no sequence or surrogate
// is open and no result waits.
module utf8_decoder_surrogate_filter_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  utf8d_pkg::in_item_t  in_item,
	output logic                 empty,
	input  logic                 pop,
	output utf8d_pkg::out_item_t out_item
);
	import utf8d_pkg::*;

	logic   in_ok, wr, q_rd;
	entry_t wr_entry, head;

	assign in_ok = push && !full;

	utf8d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ok    (in_ok),
		.in_item  (in_item),
		.wr       (wr),
		.wr_entry (wr_entry)
	);

	utf8d_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.wr_entry (wr_entry),
		.rd       (q_rd),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	utf8d_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_empty  (empty),
		.pop      (pop),
		.q_rd     (q_rd),
		.out_item (out_item)
	);

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the UTF-8 decoder with surrogate pairing. A directed
// byte run hits the edge cases, then a random mix of well-formed characters,
// surrogate pairs, lax or cut-short sequences, noise and end-of-stream marks
// follows. Results are predicted per accepted beat and checked in order.
// ----------------------------------------------------------------------------
module testbench;
	import utf8d_pkg::*;

	localparam int N_ITEMS        = 600;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_AT        = 150;
	localparam int HOLD_CYCLES    = 120;
	localparam int DRAIN_A        = 30;
	localparam int DRAIN_B        = 350;
	localparam int MAX_SHOWN      = 10;

	typedef struct {
		in_item_t item;
		bit       drain;
	} byte_beat_t;

	logic      clk;
	logic      arst_n;
	logic      push;
	logic      full;
	in_item_t  in_item;
	logic      empty;
	logic      pop;
	out_item_t out_item;

	utf8_decoder_surrogate_filter_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_item  (in_item),
		.empty    (empty),
		.pop      (pop),
		.out_item (out_item)
	);

	byte_beat_t byte_stream[$];
	out_item_t  expected_cps[$];
	out_item_t  step_cps[$];

	// decoder shadow state
	logic [CP_W-1:0] acc_value;
	logic [1:0]      need_cnt;
	logic [1:0]      seq_len;
	logic            hi_held;
	logic [9:0]      hi_bits;

	logic in_fire;
	logic out_fire;
	int   send_wait;
	int   take_wait;
	bit   send_brisk;
	bit   take_brisk;
	int   hold_left;
	bit   hold_done;
	int   idle_cycles;
	int   fail_count;
	int   n_beats;
	int   n_results;
	int   n_repl;
	int   n_ends;
	int   n_supp;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor
	function automatic void clear_decoder();
		acc_value = '0;
		need_cnt  = '0;
		seq_len   = '0;
		hi_held   = 1'b0;
		hi_bits   = '0;
	endfunction

	function automatic void emit(logic [CP_W-1:0] cp, logic rep, logic fin);
		out_item_t r;
		r.code_point = cp;
		r.replaced   = rep;
		r.stream_end = fin;
		r.last       = 1'b0;
		step_cps.push_back(r);
	endfunction

	// surrogate stage: one decoded character or one error
	function automatic void pair_unit(logic is_err, logic [CP_W-1:0] cp);
		if (hi_held) begin
			hi_held = 1'b0;
			if (is_err) begin
				emit(CP_REPL, 1'b1, 1'b0);
				return;
			end
			if (cp[15:10] == SUR_LOW) begin
				emit(CP_SUPP + {hi_bits, cp[9:0]}, 1'b0, 1'b0);
				return;
			end
			emit(CP_REPL, 1'b1, 1'b0);
		end
		if (is_err)
			emit(CP_REPL, 1'b1, 1'b0);
		else if (cp[15:10] == SUR_HIGH) begin
			hi_held = 1'b1;
			hi_bits = cp[9:0];
		end else if (cp[15:10] == SUR_LOW)
			emit(CP_REPL, 1'b1, 1'b0);
		else
			emit(cp, 1'b0, 1'b0);
	endfunction

	function automatic void take_lead(logic [7:0] b);
		if (b < 8'h80)
			pair_unit(1'b0, CP_W'(b));
		else if (b < 8'hC2)
			pair_unit(1'b1, '0);
		else if (b < 8'hE0) begin
			acc_value = CP_W'(b[4:0]);
			need_cnt  = 2'd1;
			seq_len   = 2'd1;
		end else if (b < 8'hF0) begin
			acc_value = CP_W'(b[3:0]);
			need_cnt  = 2'd2;
			seq_len   = 2'd2;
		end else if (b < 8'hF5) begin
			acc_value = CP_W'(b[2:0]);
			need_cnt  = 2'd3;
			seq_len   = 2'd3;
		end else
			pair_unit(1'b1, '0);
	endfunction

	function automatic void decode_step(in_item_t it);
		logic [CP_W-1:0] least;
		logic [CP_W-1:0] v;
		out_item_t       r;
		step_cps.delete();
		if (it.end_of_stream) begin
			if (need_cnt != 0 || hi_held)
				emit(CP_REPL, 1'b1, 1'b0);
			emit('0, 1'b0, 1'b1);
			clear_decoder();
		end else if (need_cnt != 0) begin
			if (it.data_byte[7:6] == 2'b10) begin
				acc_value = {acc_value[CP_W-7:0], it.data_byte[5:0]};
				need_cnt  = need_cnt - 2'd1;
				if (need_cnt == 0) begin
					least = (seq_len == 2'd1) ? MIN_LEN1 :
					        (seq_len == 2'd2) ? MIN_LEN2 : MIN_LEN3;
					v         = acc_value;
					acc_value = '0;
					seq_len   = '0;
					if (v < least || v > CP_MAX)
						pair_unit(1'b1, '0);
					else
						pair_unit(1'b0, v);
				end
			end else begin
				need_cnt  = '0;
				seq_len   = '0;
				acc_value = '0;
				pair_unit(1'b1, '0);
				take_lead(it.data_byte);
			end
		end else
			take_lead(it.data_byte);
		if (step_cps.size() != 0) begin
			r      = step_cps.pop_back();
			r.last = 1'b1;
			step_cps.push_back(r);
		end
		foreach (step_cps[i])
			expected_cps.push_back(step_cps[i]);
	endfunction

	// ---------------------------------------------------------------- stimulus
	function automatic void queue_beat(logic [7:0] b, logic eos);
		byte_beat_t e;
		e.item.data_byte     = b;
		e.item.end_of_stream = eos;
		e.drain = (byte_stream.size() == DRAIN_A) || (byte_stream.size() == DRAIN_B);
		byte_stream.push_back(e);
	endfunction

	function automatic void queue_cp(int unsigned cp);
		if (cp < 'h80)
			queue_beat(8'(cp), 1'b0);
		else if (cp < 'h800) begin
			queue_beat(8'(8'hC0 | (cp >> 6)), 1'b0);
			queue_beat(8'(8'h80 | (cp & 'h3F)), 1'b0);
		end else if (cp < 'h10000) begin
			queue_beat(8'(8'hE0 | (cp >> 12)), 1'b0);
			queue_beat(8'(8'h80 | ((cp >> 6) & 'h3F)), 1'b0);
			queue_beat(8'(8'h80 | (cp & 'h3F)), 1'b0);
		end else begin
			queue_beat(8'(8'hF0 | (cp >> 18)), 1'b0);
			queue_beat(8'(8'h80 | ((cp >> 12) & 'h3F)), 1'b0);
			queue_beat(8'(8'h80 | ((cp >> 6) & 'h3F)), 1'b0);
			queue_beat(8'(8'h80 | (cp & 'h3F)), 1'b0);
		end
	endfunction

	// any multi-byte lead (C2..F4) with random continuations: overlong and too-large values show up
	function automatic void queue_lax_seq(bit cut_short);
		int unsigned lead;
		int          n;
		lead = $urandom_range(8'hC2, 8'hF4);
		n    = (lead < 8'hE0) ? 1 : (lead < 8'hF0) ? 2 : 3;
		if (cut_short)
			n = $urandom_range(0, n - 1);
		queue_beat(8'(lead), 1'b0);
		repeat (n)
			queue_beat(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
	endfunction

	initial begin
		logic [7:0] directed_bytes[27];
		int         pick;
		arst_n  = 1'b0;
		push    = 1'b0;
		pop     = 1'b0;
		in_item = '0;
		clear_decoder();

		directed_bytes = '{8'h00, 8'h7F, 8'h80, 8'hC1, 8'hF5, 8'hFF,
		                   8'hE0, 8'h80, 8'h80,
		                   8'hF4, 8'h90, 8'h80, 8'h80,
		                   8'hED, 8'hA0, 8'h80, 8'hED, 8'hB0, 8'h80,
		                   8'hED, 8'hA0, 8'h80, 8'hFF,
		                   8'hC2, 8'h41,
		                   8'hF0, 8'h9D};
		foreach (directed_bytes[i])
			queue_beat(directed_bytes[i], 1'b0);
		queue_beat(8'hA5, 1'b1);
		// supplementary value whose low bits look like a high surrogate
		queue_cp('h1D800);
		queue_cp('hDC00);

		while (byte_stream.size() < N_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 18)
				queue_cp($urandom_range(0, 'h7F));
			else if (pick < 30)
				queue_cp($urandom_range('h80, 'h7FF));
			else if (pick < 42)
				queue_cp($urandom_range('h800, 'hFFFF));
			else if (pick < 52)
				queue_cp($urandom_range('h10000, 'h10FFFF));
			else if (pick < 64) begin
				queue_cp($urandom_range('hD800, 'hDBFF));
				queue_cp($urandom_range('hDC00, 'hDFFF));
			end else if (pick < 70)
				queue_cp($urandom_range('hD800, 'hDBFF));
			else if (pick < 74)
				queue_cp($urandom_range('hDC00, 'hDFFF));
			else if (pick < 82)
				queue_lax_seq(1'b0);
			else if (pick < 88)
				queue_lax_seq(1'b1);
			else if (pick < 96)
				queue_beat(8'($urandom_range(0, 255)), 1'b0);
			else
				queue_beat(8'($urandom_range(0, 255)), 1'b1);
		end
		queue_beat(8'($urandom_range(0, 255)), 1'b1);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (byte_stream.size() != 0)
			@(negedge clk);
		while (expected_cps.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		$display("covered %0d beats -> %0d results: %0d replacements, %0d supplementary,",
		         n_beats, n_results, n_repl, n_supp);
		$display("%0d stream ends, one long receiver stall and two sender drains", n_ends);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// ---------------------------------------------------------------- driver
	always @(negedge clk) begin
		logic nxt_push;
		if (arst_n) begin
			nxt_push = push;
			if (in_fire) begin
				void'(byte_stream.pop_front());
				nxt_push = 1'b0;
				if ($urandom_range(0, 29) == 0)
					send_brisk = !send_brisk;
				send_wait = send_brisk ? 0 : $urandom_range(0, 11);
			end
			if (!nxt_push && byte_stream.size() != 0) begin
				if (send_wait > 0)
					send_wait--;
				else if (!(byte_stream[0].drain && expected_cps.size() != 0)) begin
					nxt_push = 1'b1;
					in_item <= byte_stream[0].item;
				end
			end
			push <= nxt_push;
		end
	end

	// ---------------------------------------------------------------- receiver
	always @(negedge clk) begin
		logic nxt_pop;
		if (arst_n) begin
			nxt_pop = pop;
			if (out_fire) begin
				nxt_pop = 1'b0;
				if ($urandom_range(0, 29) == 0)
					take_brisk = !take_brisk;
				take_wait = take_brisk ? 0 : $urandom_range(0, 11);
				if (n_results >= HOLD_AT && !hold_done) begin
					hold_done = 1'b1;
					hold_left = HOLD_CYCLES;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				nxt_pop = 1'b0;
			end else if (!nxt_pop) begin
				if (take_wait > 0)
					take_wait--;
				else
					nxt_pop = 1'b1;
			end
			pop <= nxt_pop;
		end
	end

	// ---------------------------------------------------------------- monitor
	always @(posedge clk) begin
		out_item_t want;
		in_fire  <= arst_n && push && !full;
		out_fire <= arst_n && pop && !empty;
		if (arst_n) begin
			if (push && !full) begin
				n_beats++;
				decode_step(in_item);
			end
			if (pop && !empty) begin
				n_results++;
				if (out_item.replaced)
					n_repl++;
				if (out_item.stream_end)
					n_ends++;
				if (!out_item.replaced && out_item.code_point >= CP_SUPP)
					n_supp++;
				if (expected_cps.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_SHOWN)
						$display("unexpected beat: cp=%h rep=%b end=%b last=%b",
						         out_item.code_point, out_item.replaced,
						         out_item.stream_end, out_item.last);
				end else begin
					want = expected_cps.pop_front();
					if (out_item !== want) begin
						fail_count++;
						if (fail_count <= MAX_SHOWN)
							$display("mismatch: exp cp=%h rep=%b end=%b last=%b / got cp=%h rep=%b end=%b last=%b",
							         want.code_point, want.replaced, want.stream_end,
							         want.last, out_item.code_point, out_item.replaced,
							         out_item.stream_end, out_item.last);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------- watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

endmodule
